// ----- rtl/mse_pkg.sv -----
package mse_pkg;

	localparam int LEAD_ZERO_CELLS_DEF = 25;
	localparam int LEAD_ZERO_MAX = 25;
	localparam int TRAIL_ZERO_CELLS = 25;
	localparam int ZCNT_W = 5;
	localparam int LRC_W = 6;
	localparam int BIT_IDX_W = 3;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [7:0] OFFSET_NUMERIC = 8'h30;
	localparam logic [7:0] OFFSET_ALPHA = 8'h20;
	localparam logic [2:0] FMT_MIN = 3'd4;
	localparam logic [2:0] FMT_ALPHA = 3'd6;

	typedef enum logic [1:0] {
		KIND_START  = 2'd0,
		KIND_CHAR   = 2'd1,
		KIND_FINISH = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		REG_BITS_PER_CHAR = 2'd0,
		REG_PARITY_ODD    = 2'd1,
		REG_DRIVE_LEVEL   = 2'd2,
		REG_UNUSED        = 2'd3
	} reg_idx_t;

endpackage

// ----- rtl/mse_item_if.sv -----
interface mse_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] char_code;

	modport source (output valid, output kind, output char_code, input ready);
	modport sink (input valid, input kind, input char_code, output ready);
endinterface

// ----- rtl/mse_cell_if.sv -----
interface mse_cell_if;
	logic       valid;
	logic       ready;
	logic       first_half_level;
	logic       second_half_level;
	logic [7:0] drive;
	logic       last;

	modport source (output valid, output first_half_level, output second_half_level,
		output drive, output last, input ready);
	modport sink (input valid, input first_half_level, input second_half_level,
		input drive, input last, output ready);
endinterface

// ----- rtl/magstripe_f2f_track_encoder.sv -----
// Encodes a magnetic-stripe track into F2F bit cells, one cell per beat on the cell channel.
// Items are taken one at a time: a start item gives LEAD_ZERO_CELLS zero cells, clamped to
// 1 to 25, a character item four to seven cells depending on the format, and a finish item
// the LRC character with its parity when the format has one, followed by 25 trailing zero
// cells. A serial cell shifter produces one cell per clock cycle while the cell channel does
// not stall; the next item is taken once the last cell is in the output register.
module magstripe_f2f_track_encoder #(
	parameter int LEAD_ZERO_CELLS = mse_pkg::LEAD_ZERO_CELLS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	mse_item_if.sink                    items,
	mse_cell_if.source                  cells,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mse_pkg::PADDR_W-1:0] paddr,
	input  logic [mse_pkg::PDATA_W-1:0] pwdata,
	output logic [mse_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);

	localparam int LeadClamped = (LEAD_ZERO_CELLS < 1) ? 1 :
		((LEAD_ZERO_CELLS > mse_pkg::LEAD_ZERO_MAX) ? mse_pkg::LEAD_ZERO_MAX : LEAD_ZERO_CELLS);
	localparam logic [mse_pkg::ZCNT_W-1:0] LeadCnt = mse_pkg::ZCNT_W'(LeadClamped);
	localparam logic [mse_pkg::ZCNT_W-1:0] TrailCnt = mse_pkg::ZCNT_W'(mse_pkg::TRAIL_ZERO_CELLS);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DATA = 4'b0010,
		S_PAR  = 4'b0100,
		S_ZERO = 4'b1000
	} state_t;

	state_t                            state_q;
	logic [2:0]                        bits_per_char_q;
	logic                              parity_odd_q;
	logic [7:0]                        drive_level_q;
	logic                              line_q;
	logic [mse_pkg::LRC_W-1:0]         lrc_q;
	logic [mse_pkg::LRC_W-1:0]         shift_q;
	logic [mse_pkg::BIT_IDX_W-1:0]     bit_idx_q;
	logic [mse_pkg::BIT_IDX_W-1:0]     last_idx_q;
	logic [mse_pkg::ZCNT_W-1:0]        zcnt_q;
	logic                              par_q;
	logic                              has_par_q;
	logic                              finish_q;
	logic                              out_valid_q;
	logic                              out_first_q;
	logic                              out_second_q;
	logic [7:0]                        out_drive_q;
	logic                              out_last_q;

	logic                              cfg_wr;
	mse_pkg::reg_idx_t                 cfg_idx;
	logic                              accept;
	logic                              emit;
	logic                              cell_bit;
	logic                              cell_first;
	logic                              cell_second;
	logic                              cell_last;
	logic                              alpha_fmt;
	logic [7:0]                        code;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign cfg_idx = mse_pkg::reg_idx_t'(paddr[3:2]);

	always_comb begin
		prdata = '0;
		case (cfg_idx)
			mse_pkg::REG_BITS_PER_CHAR: prdata[2:0] = bits_per_char_q;
			mse_pkg::REG_PARITY_ODD:    prdata[0] = parity_odd_q;
			mse_pkg::REG_DRIVE_LEVEL:   prdata[7:0] = drive_level_q;
			default:                    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_per_char_q <= 3'd5;
			parity_odd_q <= 1'b1;
			drive_level_q <= 8'hFF;
		end else if (cfg_wr) begin
			case (cfg_idx)
				mse_pkg::REG_BITS_PER_CHAR: bits_per_char_q <= pwdata[2:0];
				mse_pkg::REG_PARITY_ODD:    parity_odd_q <= pwdata[0];
				mse_pkg::REG_DRIVE_LEVEL:   drive_level_q <= pwdata[7:0];
				default:                    ;
			endcase
		end
	end

	assign items.ready = (state_q == S_IDLE);
	assign accept = items.valid && items.ready;
	assign emit = (state_q != S_IDLE) && (!out_valid_q || cells.ready);

	assign alpha_fmt = (bits_per_char_q >= mse_pkg::FMT_ALPHA);
	assign code = items.char_code - (alpha_fmt ? mse_pkg::OFFSET_ALPHA : mse_pkg::OFFSET_NUMERIC);

	always_comb begin
		cell_bit = 1'b0;
		cell_last = 1'b0;
		case (state_q)
			S_DATA: begin
				cell_bit = shift_q[0];
				cell_last = (bit_idx_q == last_idx_q) && !has_par_q && !finish_q;
			end
			S_PAR: begin
				cell_bit = parity_odd_q ? par_q : !par_q;
				cell_last = !finish_q;
			end
			S_ZERO: begin
				cell_bit = 1'b0;
				cell_last = (zcnt_q == mse_pkg::ZCNT_W'(1));
			end
			default: begin
				cell_bit = 1'b0;
				cell_last = 1'b0;
			end
		endcase
	end

	assign cell_first = !line_q;
	assign cell_second = cell_first ^ cell_bit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			line_q <= 1'b0;
			lrc_q <= '0;
			shift_q <= '0;
			bit_idx_q <= '0;
			last_idx_q <= '0;
			zcnt_q <= '0;
			par_q <= 1'b1;
			has_par_q <= 1'b0;
			finish_q <= 1'b0;
		end else if (accept) begin
			bit_idx_q <= '0;
			par_q <= 1'b1;
			last_idx_q <= alpha_fmt ? mse_pkg::BIT_IDX_W'(5) : mse_pkg::BIT_IDX_W'(3);
			has_par_q <= (bits_per_char_q >= mse_pkg::FMT_MIN) && bits_per_char_q[0];
			finish_q <= (mse_pkg::kind_t'(items.kind) == mse_pkg::KIND_FINISH);
			case (mse_pkg::kind_t'(items.kind))
				mse_pkg::KIND_START: begin
					lrc_q <= '0;
					line_q <= 1'b0;
					zcnt_q <= LeadCnt;
					state_q <= S_ZERO;
				end
				mse_pkg::KIND_CHAR: begin
					shift_q <= code[mse_pkg::LRC_W-1:0];
					state_q <= S_DATA;
				end
				mse_pkg::KIND_FINISH: begin
					shift_q <= lrc_q;
					state_q <= S_DATA;
				end
				default: state_q <= S_IDLE;
			endcase
		end else if (emit) begin
			line_q <= ((state_q == S_ZERO) && cell_last && finish_q) ? 1'b0 : cell_second;
			case (state_q)
				S_DATA: begin
					shift_q <= shift_q >> 1;
					par_q <= par_q ^ shift_q[0];
					bit_idx_q <= bit_idx_q + 1'b1;
					if (!finish_q) begin
						lrc_q[bit_idx_q] <= lrc_q[bit_idx_q] ^ shift_q[0];
					end
					if (bit_idx_q == last_idx_q) begin
						if (has_par_q) begin
							state_q <= S_PAR;
						end else if (finish_q) begin
							zcnt_q <= TrailCnt;
							state_q <= S_ZERO;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_PAR: begin
					if (finish_q) begin
						zcnt_q <= TrailCnt;
						state_q <= S_ZERO;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_ZERO: begin
					zcnt_q <= zcnt_q - 1'b1;
					if (cell_last) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (cells.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_first_q <= cell_first;
			out_second_q <= cell_second;
			out_drive_q <= drive_level_q;
			out_last_q <= cell_last;
		end
	end

	assign cells.valid = out_valid_q;
	assign cells.first_half_level = out_first_q;
	assign cells.second_half_level = out_second_q;
	assign cells.drive = out_drive_q;
	assign cells.last = out_last_q;

	a_release_low: assert property (@(posedge clk) disable iff (!arst_n)
		emit && (state_q == S_ZERO) && finish_q && cell_last |=> !line_q)
		else $error("coil not released low after the finish item");

	a_zero_cell_flat: assert property (@(posedge clk) disable iff (!arst_n)
		emit && (state_q == S_ZERO) |=> out_first_q == out_second_q)
		else $error("zero cell carries a mid-cell transition");

	a_bit_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DATA) |-> bit_idx_q <= last_idx_q)
		else $error("data bit index ran past the character width");

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		emit && !cell_last |=> !items.ready)
		else $error("item taken before the current item finished");

endmodule
